/* hw/rtl/glcm_pkg.sv */
// shared constants and types for the gray-level co-occurrence accumulator
package glcm_pkg;

    // default sizing of the histogram
    localparam int COUNT_BITS_DEF  = 24;
    localparam int GRAY_LEVELS_DEF = 256;

    // width of the count on the output port
    localparam int OUT_BITS = 24;
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

    // luma weights in Q16, they sum to 65536
    localparam int LUMA_BITS = 24;
    localparam logic [LUMA_BITS-1:0] W_RED      = 24'd19595;
    localparam logic [LUMA_BITS-1:0] W_GREEN    = 24'd38470;
    localparam logic [LUMA_BITS-1:0] W_BLUE     = 24'd7471;
    localparam logic [LUMA_BITS-1:0] LUMA_ROUND = 24'd32768;

    // request codes on the input channel
    typedef enum logic
    {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

endpackage

/* hw/rtl/glcm_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
module glcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // a read in the same cycle as a write to that entry returns the old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/glcm_horizontal_accumulator_core.sv */
// top level of the horizontal gray-level co-occurrence accumulator
//
//  channel | signals                                            | moves
//  --------+----------------------------------------------------+---------------------------
//  in      | in_valid, in_ready, opcode, red, green, blue,       | one pixel or one read
//          | row_end, first_level, second_level                  | request per transfer
//  out     | out_valid, out_ready, pair_count                    | one count per read request
//
//  a pixel that closes a pair issues two increments in turn on the one ram write port; a pixel
//  without a left neighbor issues none; a read issues one ram read, but not while the previous
//  read is in the ram stage or a count stalls at the output; a read passes the input stage,
//  the ram stage and the output register; after reset a clearing pass writes zero to all
//  GRAY_LEVELS^2 entries (rounded up to a power of two, 65536 at the defaults) with in_ready low
//  a stalled output holds one count; pixels flow on until a read waits in the input stage
module glcm_horizontal_accumulator_core #(
    parameter int COUNT_BITS  = glcm_pkg::COUNT_BITS_DEF,
    parameter int GRAY_LEVELS = glcm_pkg::GRAY_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic                          row_end,
    input  logic [7:0]                    first_level,
    input  logic [7:0]                    second_level,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [glcm_pkg::OUT_BITS-1:0] pair_count
);

    import glcm_pkg::*;

    localparam int LEVEL_BITS = $clog2(GRAY_LEVELS);
    localparam int ADDR_BITS  = 2 * LEVEL_BITS;
    localparam int MEM_DEPTH  = 1 << ADDR_BITS;
    localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam logic [LEVEL_BITS-1:0] TOP_LEVEL = LEVEL_BITS'(GRAY_LEVELS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // input stage
    logic                  s1_valid_reg, s1_valid_next;
    opcode_t               s1_op_reg;
    logic                  s1_row_end_reg;
    logic [LEVEL_BITS-1:0] s1_gray_reg;
    logic [LEVEL_BITS-1:0] s1_first_reg;
    logic [LEVEL_BITS-1:0] s1_second_reg;
    logic                  s1_in_range_reg;

    // row pairing state
    logic                  have_prev_reg, have_prev_next;
    logic [LEVEL_BITS-1:0] prev_gray_reg, prev_gray_next;
    logic                  phase_reg, phase_next;

    // ram access stage
    logic                  p_valid_reg, p_valid_next;
    logic                  p_read_reg;
    logic                  p_zero_reg;
    logic [ADDR_BITS-1:0]  p_addr_reg;

    // last write, for forwarding into a read that overlapped it
    logic                  fwd_en_reg;
    logic [ADDR_BITS-1:0]  fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    // clearing pass
    logic                  clear_active_reg, clear_active_next;
    logic [ADDR_BITS-1:0]  clear_addr_reg, clear_addr_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   pair_count_reg;

    logic                  in_xfer;
    logic [LUMA_BITS-1:0]  luma_sum;
    logic [7:0]            gray_raw;
    logic [LEVEL_BITS-1:0] gray_sat;
    logic                  req_in_range;

    logic                  s1_done;
    logic                  read_slot_free;
    logic                  issue;
    logic                  issue_read;
    logic [ADDR_BITS-1:0]  issue_addr;

    logic [COUNT_BITS-1:0] ram_rd_data;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  bump_en;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic                  out_load;
    logic [WIDE_BITS-1:0]  count_wide;
    logic [OUT_BITS-1:0]   count_out;

    // gray level of the incoming pixel, round half up in Q16
    always_comb
    begin
        luma_sum = W_RED * LUMA_BITS'(red) + W_GREEN * LUMA_BITS'(green)
                 + W_BLUE * LUMA_BITS'(blue) + LUMA_ROUND;
        gray_raw = luma_sum[LUMA_BITS-1 -: 8];
        if (gray_raw > 8'(GRAY_LEVELS - 1))
        begin
            gray_sat = TOP_LEVEL;
        end
        else
        begin
            gray_sat = gray_raw[LEVEL_BITS-1:0];
        end
        req_in_range = ({1'b0, first_level} < 9'(GRAY_LEVELS))
                    && ({1'b0, second_level} < 9'(GRAY_LEVELS));
    end

    // sequencer: up to two ram operations per item, one per cycle, a read waiting for a free read slot
    always_comb
    begin
        read_slot_free = !(p_valid_reg && p_read_reg) && (!out_valid_reg || out_ready);
        issue          = 1'b0;
        issue_read     = 1'b0;
        issue_addr     = '0;
        s1_done        = 1'b0;
        phase_next     = phase_reg;
        have_prev_next = have_prev_reg;
        prev_gray_next = prev_gray_reg;
        if (s1_valid_reg)
        begin
            if (s1_op_reg == OP_READ)
            begin
                if (read_slot_free)
                begin
                    issue      = 1'b1;
                    issue_read = 1'b1;
                    issue_addr = {s1_first_reg, s1_second_reg};
                    s1_done    = 1'b1;
                end
            end
            else
            begin
                if (have_prev_reg)
                begin
                    issue = 1'b1;
                    if (!phase_reg)
                    begin
                        issue_addr = {prev_gray_reg, s1_gray_reg};
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        issue_addr = {s1_gray_reg, prev_gray_reg};
                        phase_next = 1'b0;
                        s1_done    = 1'b1;
                    end
                end
                else
                begin
                    s1_done = 1'b1;
                end
                if (s1_done)
                begin
                    if (s1_row_end_reg)
                    begin
                        have_prev_next = 1'b0;
                    end
                    else
                    begin
                        have_prev_next = 1'b1;
                        prev_gray_next = s1_gray_reg;
                    end
                end
            end
        end
    end

    assign in_ready      = !clear_active_reg && (!s1_valid_reg || s1_done);
    assign in_xfer       = in_valid && in_ready;
    assign s1_valid_next = in_xfer || (s1_valid_reg && !s1_done);
    assign p_valid_next  = issue;

    // read-modify-write: forwarded or ram data, saturating increment; zero writes during the clearing pass
    always_comb
    begin
        if (fwd_en_reg && (fwd_addr_reg == p_addr_reg))
        begin
            cur_count = fwd_data_reg;
        end
        else
        begin
            cur_count = ram_rd_data;
        end
        bump_en = p_valid_reg && !p_read_reg;
        wr_en   = clear_active_reg || bump_en;
        if (clear_active_reg)
        begin
            wr_addr = clear_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_addr = p_addr_reg;
            wr_data = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
        end
    end

    // clearing pass sweep
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg)
        begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == '1)
            begin
                clear_active_next = 1'b0;
            end
        end
    end

    // read result, zero for an out-of-range request, else clipped to the port width
    always_comb
    begin
        out_load   = p_valid_reg && p_read_reg;
        count_wide = WIDE_BITS'(cur_count);
        if (p_zero_reg)
        begin
            count_out = '0;
        end
        else if (count_wide > WIDE_BITS'(OUT_MAX))
        begin
            count_out = OUT_MAX;
        end
        else
        begin
            count_out = count_wide[OUT_BITS-1:0];
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            have_prev_reg    <= 1'b0;
            prev_gray_reg    <= '0;
            phase_reg        <= 1'b0;
            p_valid_reg      <= 1'b0;
            fwd_en_reg       <= 1'b0;
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            have_prev_reg    <= have_prev_next;
            prev_gray_reg    <= prev_gray_next;
            phase_reg        <= phase_next;
            p_valid_reg      <= p_valid_next;
            fwd_en_reg       <= wr_en;
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg       <= opcode_t'(opcode);
            s1_row_end_reg  <= row_end;
            s1_gray_reg     <= gray_sat;
            s1_first_reg    <= first_level[LEVEL_BITS-1:0];
            s1_second_reg   <= second_level[LEVEL_BITS-1:0];
            s1_in_range_reg <= req_in_range;
        end
        if (issue)
        begin
            p_read_reg <= issue_read;
            p_zero_reg <= issue_read && !s1_in_range_reg;
            p_addr_reg <= issue_addr;
        end
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
        if (out_load)
        begin
            pair_count_reg <= count_out;
        end
    end

    // histogram memory
    glcm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (issue_addr),
        .rd_data (ram_rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign pair_count = pair_count_reg;

endmodule

/* hw/rtl/glcm_checker.sv */
// port-level checker for the co-occurrence accumulator, bound to the top level
module glcm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          opcode,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [glcm_pkg::OUT_BITS-1:0] pair_count
);

    import glcm_pkg::*;

    logic       read_xfer;
    logic       out_xfer;
    logic [2:0] pending_reg;

    assign read_xfer = in_valid && in_ready && (opcode == OP_READ);
    assign out_xfer  = out_valid && out_ready;

    // reads accepted whose counts have not been transferred yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(read_xfer) - 3'(out_xfer);
        end
    end

    // a stalled count holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pair_count))
        else $error("stalled count changed");

    // every count answers an accepted read
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("count without a read request");

    // input stage, ram stage and output register hold at most three reads
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd3)
        else $error("too many reads in flight");

    // in_ready is low when reset is released, as the clearing pass starts
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input taken during clearing pass");

endmodule

bind glcm_horizontal_accumulator_core glcm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pair_count (pair_count)
);

/* tb/glcm_pair_count_checker.sv */
// checker for the co-occurrence accumulator: predicts read counts and compares them
`timescale 1ns / 1ps

module glcm_pair_count_checker #(
    parameter int COUNT_BITS  = glcm_pkg::COUNT_BITS_DEF,
    parameter int GRAY_LEVELS = glcm_pkg::GRAY_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          opcode,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic                          row_end,
    input  logic [7:0]                    first_level,
    input  logic [7:0]                    second_level,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [glcm_pkg::OUT_BITS-1:0] pair_count,
    output int                            mismatch_count,
    output int                            reads_pending
);

    localparam int TABLE_SIZE = GRAY_LEVELS * GRAY_LEVELS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // shadow histogram and row pairing state
    logic [COUNT_BITS-1:0]         model_hist [TABLE_SIZE];
    logic [7:0]                    left_gray;
    logic                          left_valid;
    logic [glcm_pkg::OUT_BITS-1:0] expected_counts [$];
    int                            errs = 0;

    // luma in q16 with round half up, clamped to the table
    function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [31:0] acc;
        logic [31:0] y;
        acc = glcm_pkg::W_RED * r + glcm_pkg::W_GREEN * g + glcm_pkg::W_BLUE * b
            + glcm_pkg::LUMA_ROUND;
        y = acc >> 16;
        if (y > GRAY_LEVELS - 1)
            y = GRAY_LEVELS - 1;
        return y[7:0];
    endfunction

    // saturating increment of one histogram entry
    task automatic bump_entry(logic [7:0] a, logic [7:0] b);
        int idx;
        idx = int'(a) * GRAY_LEVELS + int'(b);
        if (idx < TABLE_SIZE && model_hist[idx] != COUNT_MAX)
            model_hist[idx] = model_hist[idx] + 1'b1;
    endtask

    // count returned for a read of entry (a, b)
    function automatic logic [glcm_pkg::OUT_BITS-1:0] lookup_count(logic [7:0] a,
                                                                  logic [7:0] b);
        logic [31:0] v;
        v = 0;
        if (int'(a) < GRAY_LEVELS && int'(b) < GRAY_LEVELS)
            v = 32'(model_hist[int'(a) * GRAY_LEVELS + int'(b)]);
        if (v > 32'(glcm_pkg::OUT_MAX))
            v = 32'(glcm_pkg::OUT_MAX);
        return v[glcm_pkg::OUT_BITS-1:0];
    endfunction

    // watch both channels, compare results, then predict the new transfer
    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0]                    gray;
        logic [glcm_pkg::OUT_BITS-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
                model_hist[i] = '0;
            left_gray = '0;
            left_valid = 1'b0;
            expected_counts.delete();
            reads_pending <= 0;
            mismatch_count <= errs;
        end
        else
        begin
            // output transfer against the oldest outstanding read
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("pair_count %0d transferred with no read outstanding", pair_count);
                    errs++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (pair_count !== want)
                    begin
                        $error("pair_count mismatch: expected %0d, actual %0d",
                               want, pair_count);
                        errs++;
                    end
                end
            end

            // input transfer
            if (in_valid && in_ready)
            begin
                if (opcode == glcm_pkg::OP_READ)
                begin
                    expected_counts.push_back(lookup_count(first_level, second_level));
                end
                else
                begin
                    gray = luma_of(red, green, blue);
                    if (left_valid)
                    begin
                        bump_entry(left_gray, gray);
                        bump_entry(gray, left_gray);
                    end
                    if (row_end)
                    begin
                        left_valid = 1'b0;
                    end
                    else
                    begin
                        left_gray = gray;
                        left_valid = 1'b1;
                    end
                end
            end
            reads_pending <= expected_counts.size();
            mismatch_count <= errs;
        end
    end

endmodule

/* tb/tb_glcm_horizontal_accumulator_core.sv */
// testbench top for the co-occurrence accumulator: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_glcm_horizontal_accumulator_core;

    import glcm_pkg::*;

    localparam int ITEM_TARGET = 500;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                opcode;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic                row_end;
    logic [7:0]          first_level;
    logic [7:0]          second_level;
    logic                out_valid;
    logic                out_ready;
    logic [OUT_BITS-1:0] pair_count;

    int   mismatch_count;
    int   reads_pending;
    int   items_sent;
    int   cycle_count;
    bit   calm;
    bit   hold_req;
    bit   draining;
    logic [7:0] palette [6];

    glcm_horizontal_accumulator_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .row_end      (row_end),
        .first_level  (first_level),
        .second_level (second_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pair_count   (pair_count)
    );

    glcm_pair_count_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .row_end        (row_end),
        .first_level    (first_level),
        .second_level   (second_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pair_count     (pair_count),
        .mismatch_count (mismatch_count),
        .reads_pending  (reads_pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL glcm_horizontal_accumulator_core");
        $finish;
    end

    // idle cycles before the next input transfer: mostly none, a few long
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // offer one item and hold it until the transfer
    task automatic drive_item(opcode_t op, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic re, logic [7:0] fl, logic [7:0] sl);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        opcode       <= op;
        red          <= r;
        green        <= g;
        blue         <= b;
        row_end      <= re;
        first_level  <= fl;
        second_level <= sl;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // pixel with random read fields, which the block ignores
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic re);
        drive_item(OP_ACCUM, r, g, b, re, 8'($urandom), 8'($urandom));
    endtask

    // read with random pixel fields, which the block ignores
    task automatic send_read(logic [7:0] fl, logic [7:0] sl);
        drive_item(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                   fl, sl);
    endtask

    // random pixel: mostly neutral gray from the palette so reads find nonzero counts
    task automatic send_random_pixel(logic re);
        logic [7:0] v;
        if ($urandom_range(0, 9) < 6)
        begin
            v = palette[$urandom_range(0, 5)];
            send_pixel(v, v, v, re);
        end
        else
        begin
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), re);
        end
    endtask

    // random read: mostly entries between palette levels
    task automatic send_random_read();
        if ($urandom_range(0, 9) < 7)
            send_read(palette[$urandom_range(0, 5)], palette[$urandom_range(0, 5)]);
        else
            send_read(8'($urandom), 8'($urandom));
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int run_left;
        int hold_left;
        int roll;
        bit rdy;
        bit hold_taken;
        run_left = 0;
        hold_left = 0;
        rdy = 1'b0;
        hold_taken = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (draining || calm)
            begin
                rdy = 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 65)
                    begin
                        rdy = 1'b1;
                        run_left = $urandom_range(1, 10);
                    end
                    else if (roll < 93)
                    begin
                        rdy = 1'b0;
                        run_left = $urandom_range(1, 3);
                    end
                    else
                    begin
                        rdy = 1'b0;
                        run_left = $urandom_range(10, 40);
                    end
                end
                run_left--;
            end
            out_ready <= rdy;
        end
    end

    // reset, stimulus and verdict
    initial
    begin
        int row_len;
        bit pressure_done;
        items_sent = 0;
        calm = 1'b0;
        hold_req = 1'b0;
        draining = 1'b0;
        pressure_done = 1'b0;
        palette[0] = 8'd0;
        palette[1] = 8'd255;
        for (int i = 2; i < 6; i++)
            palette[i] = 8'($urandom);

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        opcode       <= OP_ACCUM;
        red          <= '0;
        green        <= '0;
        blue         <= '0;
        row_end      <= 1'b0;
        first_level  <= '0;
        second_level <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: cleared table, extreme colors, row breaks, reads inside a row
        send_read(8'd0, 8'd0);
        send_read(8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_read(8'd0, 8'd255);
        send_read(8'd255, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_read(8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        send_read(8'd128, 8'd128);
        send_read(8'd255, 8'd76);
        send_read(8'd76, 8'd255);
        send_read(8'd150, 8'd29);
        send_read(8'd29, 8'd150);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        send_read(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_read(8'd255, 8'd255);

        // random rows with reads mixed in
        while (items_sent < ITEM_TARGET)
        begin
            if (!pressure_done && items_sent >= ITEM_TARGET / 2)
            begin
                // long receiver hold-off while items keep coming back to back
                pressure_done = 1'b1;
                calm = 1'b1;
                hold_req = 1'b1;
                for (int i = 0; i < 16; i++)
                begin
                    if (i % 2 == 0)
                        send_random_read();
                    else
                        send_random_pixel(1'($urandom_range(0, 3) == 0));
                end
            end
            calm = ($urandom_range(0, 4) == 0);
            row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
            for (int p = 0; p < row_len; p++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_random_read();
                send_random_pixel(p == row_len - 1);
            end
        end

        // drain
        in_valid <= 1'b0;
        calm = 1'b0;
        draining = 1'b1;
        @(posedge clk);
        while (reads_pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && reads_pending == 0)
            $display("PASS glcm_horizontal_accumulator_core");
        else
            $display("FAIL glcm_horizontal_accumulator_core");
        $finish;
    end

endmodule

/* glcm_horizontal_accumulator_core.f */
hw/rtl/glcm_pkg.sv
hw/rtl/glcm_ram.sv
hw/rtl/glcm_horizontal_accumulator_core.sv
hw/rtl/glcm_checker.sv
tb/glcm_pair_count_checker.sv
tb/tb_glcm_horizontal_accumulator_core.sv
